>>> sv/stre_pkg.sv
// Shared types and constants for the scaled text rectangle emitter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package stre_pkg;

    localparam int unsigned SCREEN_WIDTH_DEF  = 160;
    localparam int unsigned SCREEN_HEIGHT_DEF = 80;
    localparam int unsigned CMDQ_DEPTH_DEF    = 2;

    localparam int unsigned GLYPH_COLS = 5;
    localparam int unsigned GLYPH_ROWS = 7;
    localparam int unsigned GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
    // background cell plus one position per glyph bit
    localparam int unsigned RECT_SLOTS = GLYPH_BITS + 1;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    typedef enum logic [2:0] {
        CFG_TEXT_SCALE = 3'd0,
        CFG_FORE_COLOR = 3'd1,
        CFG_BACK_COLOR = 3'd2,
        CFG_ORIGIN_X   = 3'd3,
        CFG_ORIGIN_Y   = 3'd4,
        CFG_PANEL_COL  = 3'd5,
        CFG_PANEL_ROW  = 3'd6
    } t_cfg_idx;

    // one drawn character handed from the front to the back
    typedef struct packed {
        logic [RECT_SLOTS-1:0] mask;   // bit 0 background, bit 1+7c+r glyph square
        logic [9:0]            col;
        logic [9:0]            row;
        logic [3:0]            scale;  // effective scale, never zero
    } t_cmd;

endpackage

`default_nettype wire

>>> sv/stre_cmdq.sv
// Short command queue between the front and the back of the emitter.
// Depends on stre_pkg for the command type.
`default_nettype none

module stre_cmdq #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire stre_pkg::t_cmd i_push_cmd,
    output logic               o_push_ready,
    input  wire logic          i_pop,
    output stre_pkg::t_cmd     o_pop_cmd,
    output logic               o_pop_valid
);
    import stre_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= bump(r_wp);
            if (do_pop)  r_rp <= bump(r_rp);
            if (do_push && !do_pop) r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_push_cmd;
    end

endmodule

`default_nettype wire

>>> sv/stre_front.sv
// Front end: accepts characters, tracks the text cursor and stop state,
// and works out which rectangles survive clipping. Depends on stre_pkg.
`default_nettype none

module stre_front #(
    parameter int unsigned SCREEN_WIDTH  = stre_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = stre_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [34:0]   i_glyph_columns,
    input  wire logic          i_string_start,
    input  wire logic [3:0]    i_scale,
    input  wire logic [7:0]    i_origin_x,
    input  wire logic [7:0]    i_origin_y,
    output logic               o_push,
    output stre_pkg::t_cmd     o_push_cmd,
    input  wire logic          i_push_ready
);
    import stre_pkg::*;

    logic [9:0] r_col, r_row, n_col, n_row;
    logic       r_stopped, n_stopped;

    logic [9:0]            col_s, row_s;
    logic                  stop_s, accept, is_nl;
    logic [6:0]            cw, chh;
    logic [GLYPH_COLS-1:0] col_ok;
    logic [GLYPH_ROWS-1:0] row_ok;
    logic [GLYPH_BITS-1:0] pix_ok;
    logic [RECT_SLOTS-1:0] mask;
    logic [10:0]           col_adv, row_adv;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && o_ready;
    assign is_nl   = (i_char_code == CHAR_NEWLINE);

    always_comb begin
        col_s  = i_string_start ? {2'b00, i_origin_x} : r_col;
        row_s  = i_string_start ? {2'b00, i_origin_y} : r_row;
        stop_s = i_string_start ? 1'b0 : r_stopped;
        cw     = ({3'b000, i_scale} << 2) + ({3'b000, i_scale} << 1);
        chh    = {i_scale, 3'b000};

        // column and row survival are independent, a square needs both
        for (int c = 0; c < GLYPH_COLS; c++)
            col_ok[c] = (11'(col_s) + 11'(c) * 11'(i_scale)) < 11'(SCREEN_WIDTH);
        for (int r = 0; r < GLYPH_ROWS; r++)
            row_ok[r] = (11'(row_s) + 11'(r) * 11'(i_scale)) < 11'(SCREEN_HEIGHT);
        for (int c = 0; c < GLYPH_COLS; c++)
            for (int r = 0; r < GLYPH_ROWS; r++)
                pix_ok[c*GLYPH_ROWS + r] = i_glyph_columns[c*GLYPH_ROWS + r]
                                           && col_ok[c] && row_ok[r];
        mask = {pix_ok, col_ok[0] && row_ok[0]};

        // cursor advance, newline and wrap
        col_adv = 11'(col_s) + 11'(cw);
        row_adv = 11'(row_s) + 11'(chh);
        if (is_nl || (col_adv + 11'(cw) > 11'(SCREEN_WIDTH))) begin
            n_col = {2'b00, i_origin_x};
            n_row = row_adv[9:0];
        end else begin
            n_col = col_adv[9:0];
            n_row = row_s;
        end
        n_stopped = (11'(n_row) + 11'(chh)) > 11'(SCREEN_HEIGHT);
    end

    assign o_push             = accept && !stop_s && !is_nl && (mask != '0);
    assign o_push_cmd.mask    = mask;
    assign o_push_cmd.col     = col_s;
    assign o_push_cmd.row     = row_s;
    assign o_push_cmd.scale   = i_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_stopped <= 1'b0;
        end else if (accept && !stop_s) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

>>> sv/stre_back.sv
// Back end: walks the surviving rectangles of one character, one position per
// unstalled cycle; drives the registered output stream. Depends on stre_pkg.
`default_nettype none

module stre_back #(
    parameter int unsigned SCREEN_WIDTH  = stre_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = stre_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stre_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    input  wire logic [15:0]   i_fore_color,
    input  wire logic [15:0]   i_back_color,
    input  wire logic [7:0]    i_panel_col,
    input  wire logic [7:0]    i_panel_row,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_data,
    output logic               o_last
);
    import stre_pkg::*;

    typedef enum logic {ST_IDLE, ST_WALK} t_state;

    t_state                r_state;
    logic [RECT_SLOTS-1:0] r_mask;
    logic [9:0]            r_row0;
    logic [3:0]            r_s;
    logic [10:0]           r_x, r_y;
    logic [2:0]            r_r;
    logic                  r_bg;

    logic                  r_ov, r_olast;
    logic [7:0]            r_cs, r_rs, r_ce, r_re;
    logic [13:0]           r_pix;
    logic [15:0]           r_color;

    logic                  advance;
    logic [RECT_SLOTS-1:0] mask_rest;
    logic [7:0]            sw, sh, w, h;
    logic [15:0]           area;

    assign advance   = (r_state == ST_WALK) && (!r_ov || i_ready);
    assign mask_rest = r_mask >> 1;
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    always_comb begin
        sw = r_bg ? ({4'h0, r_s} << 2) + ({4'h0, r_s} << 1) : {4'h0, r_s};
        sh = r_bg ? {1'b0, r_s, 3'b000} : {4'h0, r_s};
        // clip to the screen; the front only flags positions that start on it
        w  = (r_x + 11'(sw) > 11'(SCREEN_WIDTH))  ? 8'(11'(SCREEN_WIDTH)  - r_x) : sw;
        h  = (r_y + 11'(sh) > 11'(SCREEN_HEIGHT)) ? 8'(11'(SCREEN_HEIGHT) - r_y) : sh;
        area = 16'(w) * 16'(h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_ready && !(advance && r_mask[0])) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= ST_WALK;
                        r_mask  <= i_cmd.mask;
                        r_row0  <= i_cmd.row;
                        r_s     <= i_cmd.scale;
                        r_x     <= {1'b0, i_cmd.col};
                        r_y     <= {1'b0, i_cmd.row};
                        r_r     <= '0;
                        r_bg    <= 1'b1;
                    end
                end
                ST_WALK: begin
                    if (advance) begin
                        if (r_mask[0]) begin
                            r_ov    <= 1'b1;
                            r_olast <= (mask_rest == '0);
                            r_cs    <= r_x[7:0] + i_panel_col;
                            r_rs    <= r_y[7:0] + i_panel_row;
                            r_ce    <= r_x[7:0] + w - 8'd1 + i_panel_col;
                            r_re    <= r_y[7:0] + h - 8'd1 + i_panel_row;
                            r_pix   <= area[13:0];
                            r_color <= r_bg ? i_back_color : i_fore_color;
                        end
                        r_mask <= mask_rest;
                        if (mask_rest == '0) r_state <= ST_IDLE;
                        // background and first square share the top-left corner
                        if (r_bg) begin
                            r_bg <= 1'b0;
                        end else if (r_r == 3'(GLYPH_ROWS - 1)) begin
                            r_r <= '0;
                            r_y <= {1'b0, r_row0};
                            r_x <= r_x + 11'(r_s);
                        end else begin
                            r_r <= r_r + 3'd1;
                            r_y <= r_y + 11'(r_s);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_last  = r_olast;
    assign o_data  = {2'b00, r_color, r_pix, r_re, r_ce, r_rs, r_cs};

endmodule

`default_nettype wire

>>> sv/scaled_text_rect_emitter.sv
// Scaled 5x7 text rectangle emitter: top level with configuration registers.
// Depends on stre_pkg, stre_front, stre_cmdq and stre_back.
//
// Usage:
//   s_axis carries one character per request: tdata[7:0] char_code,
//   tdata[42:8] glyph_columns (column 0 lowest), tuser = string_start.
//   m_axis returns fill-rectangle requests: window corners with panel
//   offsets, pixel count and colour in tdata; tlast marks the final
//   rectangle caused by a character. Characters that give no rectangle
//   (newline, stopped text, fully clipped cell) produce nothing.
//   The configuration port writes one register per cycle at i_cfg_we;
//   write it only while the block is idle.
// Flow:
//   A drawn character enters the command queue in the cycle it is accepted.
//   The back end loads a command while idle, then walks up to 36 positions
//   (background cell, then glyph bits column by column), one per cycle unless
//   stalled, taking the next command only after the walk; this sequencer sets
//   the rate. The first rectangle passes the queue, the command load and the
//   output register. Newlines and stopped characters stay in the front only.
// Reset:
//   Synchronous, active low: cursor to (0,0), stop cleared, queue and
//   output emptied, configuration registers to their defaults.
// Stall:
//   When m_axis_tready is low the output register holds; the walk pauses,
//   the queue fills and s_axis_tready drops once it is full.
`default_nettype none

module scaled_text_rect_emitter #(
    parameter int unsigned SCREEN_WIDTH  = stre_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = stre_pkg::SCREEN_HEIGHT_DEF,
    parameter int unsigned CMDQ_DEPTH    = stre_pkg::CMDQ_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // char_code, glyph_columns, zero pad
    input  wire logic        s_axis_tuser,   // string_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // win_col_start, win_row_start, win_col_end, win_row_end, pixel_count,
    // fill_color, zero pad
    output logic [63:0]      m_axis_tdata,
    output logic             m_axis_tlast,   // last_rect
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import stre_pkg::*;

    logic [3:0]  r_scale;
    logic [15:0] r_fore, r_back;
    logic [7:0]  r_org_x, r_org_y, r_pcol, r_prow;
    logic [3:0]  scale_eff;

    t_cmd push_cmd, pop_cmd;
    logic push, push_ready, pop, pop_valid;

    // hold registers; scale zero reads as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 4'd1;
            r_fore  <= 16'hFFFF;
            r_back  <= 16'h0000;
            r_org_x <= 8'd0;
            r_org_y <= 8'd0;
            r_pcol  <= 8'd1;
            r_prow  <= 8'd26;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEXT_SCALE: r_scale <= i_cfg_data[3:0];
                CFG_FORE_COLOR: r_fore  <= i_cfg_data;
                CFG_BACK_COLOR: r_back  <= i_cfg_data;
                CFG_ORIGIN_X:   r_org_x <= i_cfg_data[7:0];
                CFG_ORIGIN_Y:   r_org_y <= i_cfg_data[7:0];
                CFG_PANEL_COL:  r_pcol  <= i_cfg_data[7:0];
                CFG_PANEL_ROW:  r_prow  <= i_cfg_data[7:0];
                default: ;      // drop writes to unused indexes
            endcase
        end
    end

    assign scale_eff = (r_scale == 4'd0) ? 4'd1 : r_scale;

    stre_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_glyph_columns (s_axis_tdata[42:8]),
        .i_string_start  (s_axis_tuser),
        .i_scale         (scale_eff),
        .i_origin_x      (r_org_x),
        .i_origin_y      (r_org_y),
        .o_push          (push),
        .o_push_cmd      (push_cmd),
        .i_push_ready    (push_ready)
    );

    stre_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_pop_cmd    (pop_cmd),
        .o_pop_valid  (pop_valid)
    );

    stre_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (pop_cmd),
        .i_cmd_valid  (pop_valid),
        .o_cmd_pop    (pop),
        .i_fore_color (r_fore),
        .i_back_color (r_back),
        .i_panel_col  (r_pcol),
        .i_panel_row  (r_prow),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> sv/stre_checker.sv
// Port-level checks for the scaled text rectangle emitter, bound to the top.
// Depends on scaled_text_rect_emitter and stre_pkg.
`default_nettype none

module stre_checker #(
    parameter int unsigned SCREEN_WIDTH  = stre_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = stre_pkg::SCREEN_HEIGHT_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    logic [7:0]  dc, dr;
    logic [13:0] area;

    assign dc   = m_axis_tdata[23:16] - m_axis_tdata[7:0];
    assign dr   = m_axis_tdata[31:24] - m_axis_tdata[15:8];
    assign area = 14'((16'(dc) + 16'd1) * (16'(dr) + 16'd1));

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[45:32] == area)
        else $error("pixel count disagrees with window corners");

    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (9'(dc) < 9'(SCREEN_WIDTH)) && (9'(dr) < 9'(SCREEN_HEIGHT)))
        else $error("window larger than the screen");

endmodule

bind scaled_text_rect_emitter stre_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_stre_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
